@@ design/ffba_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffba_pkg
// Shared types and constants for the first-fit block allocator: table entry
// layout, status codes and the result bundle.
// ============================================================================
package ffba_pkg;

    localparam int          DEPTH_DEFAULT = 64;
    localparam int          PID_W         = 16;
    localparam int          LEN_W         = 24;
    localparam int          ENTRY_W       = 1 + PID_W + LEN_W;
    localparam int          SKIP_W        = 16;
    localparam int          IDX_OUT_W     = 6;
    localparam logic [23:0] MEM_SIZE_RST  = 24'd1048576;

    typedef enum logic [2:0] {
        ST_HOLE     = 3'd0,
        ST_APPEND   = 3'd1,
        ST_SKIP     = 3'd2,
        ST_FREED    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // One table entry: free flag, owning pid, block length.
    typedef struct packed {
        logic             free;
        logic [PID_W-1:0] pid;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] index;
        logic [LEN_W-1:0]     extent;
        logic [SKIP_W-1:0]    skipped;
    } t_result;

endpackage

@@ design/ffba_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffba_ram
// Block table storage: one write port, one read port, registered read data.
// ============================================================================
module ffba_ram
    import ffba_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ffba_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffba_ctrl
// Sequencer: scans the table one entry at a time (read, then compare), shifts
// entries up to open a slot, and keeps block count, extent and skip count.
// ============================================================================
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_command,
    input  logic [PID_W-1:0] i_pid,
    input  logic [LEN_W-1:0] i_size,
    input  logic [LEN_W-1:0] i_capacity,
    output logic             o_busy,
    output logic             o_valid,
    output t_result          o_result,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output t_entry           o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  t_entry           i_mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_SH_RD,
        S_SH_WR,
        S_WR_HOLE,
        S_WR_NEW,
        S_APPEND
    } t_state;

    localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);

    t_state           r_state,   n_state;
    logic             r_cmd,     n_cmd;
    logic [PID_W-1:0] r_pid,     n_pid;
    logic [LEN_W-1:0] r_size,    n_size;
    logic [AW:0]      r_count,   n_count;
    logic [AW:0]      r_idx,     n_idx;
    logic [AW-1:0]    r_hit,     n_hit;
    t_entry           r_hole,    n_hole;
    logic [LEN_W-1:0] r_extent,  n_extent;
    logic [SKIP_W-1:0] r_skip,   n_skip;
    logic             r_any_hole, n_any_hole;
    logic             r_valid,   n_valid;
    t_result          r_res,     n_res;

    logic             full;
    logic [AW:0]      idx_p1;
    logic [AW:0]      idx_m1;
    logic [AW:0]      hit_p1;
    logic [LEN_W:0]   sum;
    logic             hit_free;
    logic             hit_alloc;

    function automatic logic [IDX_OUT_W-1:0] to_idx(input logic [AW-1:0] v);
        logic [AW+IDX_OUT_W-1:0] w;
        w = {{IDX_OUT_W{1'b0}}, v};
        return w[IDX_OUT_W-1:0];
    endfunction

    assign full      = (r_count >= DEPTH_C);
    assign idx_p1    = r_idx + 1'b1;
    assign idx_m1    = r_idx - 1'b1;
    assign hit_p1    = {1'b0, r_hit} + 1'b1;
    assign sum       = {1'b0, r_extent} + {1'b0, r_size};
    assign hit_free  = r_cmd && !i_mem_rdata.free && (i_mem_rdata.pid == r_pid);
    assign hit_alloc = !r_cmd && i_mem_rdata.free && (r_size <= i_mem_rdata.len);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_pid      = r_pid;
        n_size     = r_size;
        n_count    = r_count;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hole     = r_hole;
        n_extent   = r_extent;
        n_skip     = r_skip;
        n_any_hole = r_any_hole;
        n_valid    = 1'b0;
        n_res      = r_res;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd  = i_command;
                    n_pid  = i_pid;
                    n_size = i_size;
                    n_idx  = '0;
                    if ((i_command || r_any_hole) && (r_count != '0)) begin
                        n_state = S_RD;
                    end else if (i_command) begin
                        n_valid      = 1'b1;
                        n_res.status = ST_NOTFOUND;
                        n_res.index  = '0;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (hit_free) begin
                    // Mark the owned block free; length stays.
                    o_mem_we          = 1'b1;
                    o_mem_wdata.free  = 1'b1;
                    n_any_hole        = 1'b1;
                    n_valid           = 1'b1;
                    n_res.status      = ST_FREED;
                    n_res.index       = to_idx(r_idx[AW-1:0]);
                    n_state           = S_IDLE;
                end else if (hit_alloc) begin
                    if (full) begin
                        n_valid      = 1'b1;
                        n_res.status = ST_FULL;
                        n_res.index  = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_hole = i_mem_rdata;
                        n_hit  = r_idx[AW-1:0];
                        if (r_count > idx_p1) begin
                            n_idx   = r_count;
                            n_state = S_SH_RD;
                        end else begin
                            n_state = S_WR_HOLE;
                        end
                    end
                end else if (idx_p1 == r_count) begin
                    if (r_cmd) begin
                        n_valid      = 1'b1;
                        n_res.status = ST_NOTFOUND;
                        n_res.index  = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                o_mem_raddr = idx_m1[AW-1:0];
                n_state     = S_SH_WR;
            end
            S_SH_WR: begin
                // Move entry j-1 up to j.
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx[AW-1:0];
                o_mem_wdata = i_mem_rdata;
                n_idx       = idx_m1;
                n_state     = (idx_m1 > hit_p1) ? S_SH_RD : S_WR_HOLE;
            end
            S_WR_HOLE: begin
                o_mem_we         = 1'b1;
                o_mem_waddr      = hit_p1[AW-1:0];
                o_mem_wdata      = r_hole;
                o_mem_wdata.len  = r_hole.len - r_size;
                n_state          = S_WR_NEW;
            end
            S_WR_NEW: begin
                o_mem_we         = 1'b1;
                o_mem_waddr      = r_hit;
                o_mem_wdata.free = 1'b0;
                o_mem_wdata.pid  = r_pid;
                o_mem_wdata.len  = r_size;
                n_count          = r_count + 1'b1;
                n_valid          = 1'b1;
                n_res.status     = ST_HOLE;
                n_res.index      = to_idx(r_hit);
                n_state          = S_IDLE;
            end
            S_APPEND: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (sum <= {1'b0, i_capacity}) begin
                    if (full) begin
                        n_res.status = ST_FULL;
                        n_res.index  = '0;
                    end else begin
                        o_mem_we         = 1'b1;
                        o_mem_waddr      = r_count[AW-1:0];
                        o_mem_wdata.free = 1'b0;
                        o_mem_wdata.pid  = r_pid;
                        o_mem_wdata.len  = r_size;
                        n_count          = r_count + 1'b1;
                        n_extent         = sum[LEN_W-1:0];
                        n_res.status     = ST_APPEND;
                        n_res.index      = to_idx(r_count[AW-1:0]);
                    end
                end else begin
                    if (r_skip != '1) begin
                        n_skip = r_skip + 1'b1;
                    end
                    n_res.status = ST_SKIP;
                    n_res.index  = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_valid) begin
            n_res.extent  = n_extent;
            n_res.skipped = n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_extent   <= '0;
            r_skip     <= '0;
            r_any_hole <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_extent   <= n_extent;
            r_skip     <= n_skip;
            r_any_hole <= n_any_hole;
            r_valid    <= n_valid;
        end
        r_cmd  <= n_cmd;
        r_pid  <= n_pid;
        r_size <= n_size;
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_hole <= n_hole;
        r_res  <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

@@ design/first_fit_block_allocator_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// first_fit_block_allocator_top
// First-fit allocator over an ordered table of owned and free blocks.
// ============================================================================
// Command channel: drive i_command, i_pid and i_request_size with start high;
//   the command transfers at the rising edge where start is high and busy is
//   low. busy stays high until the command has finished.
// Result channel: o_valid pulses for one cycle with o_status, o_block_index,
//   o_used_extent and o_skipped_total. The receiver cannot stall; sample it in
//   that cycle or lose it. Configuration: i_cfg_we writes i_cfg_wdata into
//   the capacity register at the clock edge; write it only while busy is low.
// Timing: the table sits in a RAM with registered read data, so each scanned
//   entry passes a read state and a compare state, and each entry moved to
//   open a slot a read state and a write state. An insert then writes the
//   split hole and the new block; an allocation that finds no hole goes on
//   to the append step. The result strobes in the first cycle with busy low.
//   An append without a scan goes straight to the append step, and a free on
//   an empty table answers without busy.
// Reset: i_rst_n (synchronous, active low) empties the table, clears extent
//   and skip count, and sets the capacity to 1048576. No clearing pass.
// ============================================================================
module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [PID_W-1:0]  i_pid,
    input  logic [LEN_W-1:0]  i_request_size,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [IDX_OUT_W-1:0] o_block_index,
    output logic [LEN_W-1:0]  o_used_extent,
    output logic [SKIP_W-1:0] o_skipped_total,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [LEN_W-1:0] r_capacity;

    t_result       result;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    // Hold the capacity register; write it whenever enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Sequencer: scan, shift and bookkeeping.
    ffba_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_command     (i_command),
        .i_pid         (i_pid),
        .i_size        (i_request_size),
        .i_capacity    (r_capacity),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_result      (result),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    // Block table: owner and length of every entry, one word each.
    ffba_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Unpack the registered result bundle onto the result ports.
    assign o_status        = result.status;
    assign o_block_index   = result.index;
    assign o_used_extent   = result.extent;
    assign o_skipped_total = result.skipped;

endmodule
